// File: hdl/rotation_phase_hue_generator_top_macros.svh
// Assertion helpers shared by the design files.
// Every check is clocked on clk and switched off while rst_n is low.
`ifndef ROTATION_PHASE_HUE_GENERATOR_TOP_MACROS_SVH
`define ROTATION_PHASE_HUE_GENERATOR_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RPHG_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rphg check failed");

// The consequent must hold in the cycle after the antecedent.
`define RPHG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rphg check failed");

`endif

// File: hdl/rphg_pkg.sv
`timescale 1ns / 1ps
package rphg_pkg;

    localparam int NUM_LEDS  = 44;
    localparam int AVG_DEPTH = 5;

    // A sum of AVG_DEPTH 32-bit intervals, and elapsed times AVG_DEPTH, fit in SUM_W bits.
    localparam int SUM_W = 32 + $clog2(AVG_DEPTH);
    // elapsed * AVG_DEPTH * 255 is at most eight bits wider.
    localparam int NUM_W = SUM_W + 8;
    localparam int POS_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
    localparam int LED_W = 6;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    // Operation codes
    localparam logic OP_PULSE = 1'b0;
    localparam logic OP_FRAME = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT_MS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL          = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HUE_STEP       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ARM_HUE_OFFSET = 2'd3;

    // Register reset values
    localparam logic [15:0] LOCKOUT_MS_RST     = 16'd50;
    localparam logic [7:0]  LEVEL_RST          = 8'd80;
    localparam logic [7:0]  HUE_STEP_RST       = 8'd2;
    localparam logic [7:0]  ARM_HUE_OFFSET_RST = 8'd128;

    typedef struct packed {
        logic        op;
        logic [31:0] now_ms;
    } in_item_t;

    typedef struct packed {
        logic [LED_W-1:0] led_index;
        logic [7:0]       hue_a;
        logic [7:0]       hue_b;
        logic [7:0]       value_level;
        logic             last;
    } out_item_t;

    typedef struct packed {
        logic [7:0] level;
        logic [7:0] hue_step;
        logic [7:0] arm_hue_offset;
    } led_cfg_t;

    typedef struct packed {
        logic       done;
        logic [7:0] phase;
    } div_res_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PULSE,
        S_SUMWAIT,
        S_FRAME,
        S_DIV,
        S_EMIT
    } ctl_state_t;

    typedef enum logic [1:0] {
        D_IDLE,
        D_PREP,
        D_RUN
    } div_state_t;

endpackage

// File: hdl/rotation_phase_hue_generator_top.sv
// Rotation phase and hue generator. A hall pulse item (op 0) closes one rotation interval
// unless it comes sooner than lockout_ms after the last accepted pulse; accepted intervals
// fill a ring of AVG_DEPTH entries whose running sum is kept in a register. A frame item
// (op 1) works out the phase floor(elapsed*255*AVG_DEPTH/sum), zero for an empty ring or an
// overdue frame, and then sends NUM_LEDS results, one per cycle while out_stall is low,
// with last set on the final one. A pulse item goes through S_PULSE and then S_SUMWAIT, or
// back to S_IDLE from S_PULSE when the lockout throws it away; a frame item goes through
// S_FRAME, S_DIV and S_EMIT; the restoring divider finds one phase bit per cycle. The
// next item is taken while the final result of a frame still waits on the output register.
// Configuration on cfg_we is to be written only while idle; the block does not enforce it.
`timescale 1ns / 1ps
`include "rotation_phase_hue_generator_top_macros.svh"
module rotation_phase_hue_generator_top
    import rphg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_item_t              in_item,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_item,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    ctl_state_t  state_reg, state_next;
    logic [15:0] lockout_reg;
    led_cfg_t    led_cfg_reg;
    logic [31:0] last_pulse_reg;
    logic [31:0] now_reg;
    logic [31:0] elapsed_reg;
    logic        op_reg;

    logic             in_accept;
    logic             ring_wr;
    logic             div_start;
    logic             emit_start;
    logic             emit_busy;
    logic             ring_busy;
    logic [SUM_W-1:0] ring_sum;
    div_res_t         div_res;

    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg                  <= S_IDLE;
            lockout_reg                <= LOCKOUT_MS_RST;
            led_cfg_reg.level          <= LEVEL_RST;
            led_cfg_reg.hue_step       <= HUE_STEP_RST;
            led_cfg_reg.arm_hue_offset <= ARM_HUE_OFFSET_RST;
            last_pulse_reg             <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (ring_wr)
            begin
                last_pulse_reg <= now_reg;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_LOCKOUT_MS:     lockout_reg                <= cfg_wdata;
                    CFG_LEVEL:          led_cfg_reg.level          <= cfg_wdata[7:0];
                    CFG_HUE_STEP:       led_cfg_reg.hue_step       <= cfg_wdata[7:0];
                    CFG_ARM_HUE_OFFSET: led_cfg_reg.arm_hue_offset <= cfg_wdata[7:0];
                    default:            ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg      <= in_item.op;
            now_reg     <= in_item.now_ms;
            elapsed_reg <= in_item.now_ms - last_pulse_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ring_wr    = 1'b0;
        div_start  = 1'b0;
        emit_start = 1'b0;
        in_stall   = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    state_next = (in_item.op == OP_FRAME) ? S_FRAME : S_PULSE;
                end
            end
            S_PULSE:
            begin
                // A pulse inside the lockout window leaves the ring, its sum and the last pulse time alone.
                if (elapsed_reg >= {16'd0, lockout_reg})
                begin
                    ring_wr    = 1'b1;
                    state_next = S_SUMWAIT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_SUMWAIT:
            begin
                if (!ring_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            S_FRAME:
            begin
                div_start  = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_res.done)
                begin
                    emit_start = 1'b1;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!emit_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    rphg_ring u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (ring_wr),
        .wr_data (elapsed_reg),
        .sum     (ring_sum),
        .busy    (ring_busy)
    );

    rphg_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .elapsed (elapsed_reg),
        .sum     (ring_sum),
        .res     (div_res)
    );

    rphg_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (emit_start),
        .phase     (div_res.phase),
        .cfg       (led_cfg_reg),
        .busy      (emit_busy),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    `RPHG_ASSERT_NOW(a_done_in_div, div_res.done, state_reg == S_DIV)
    `RPHG_ASSERT_NOW(a_ring_quiet_on_accept, in_accept, !ring_busy)
    `RPHG_ASSERT_NOW(a_frame_op_kept, state_reg == S_FRAME, op_reg == OP_FRAME)

endmodule

// File: hdl/rphg_ring.sv
`timescale 1ns / 1ps
`include "rotation_phase_hue_generator_top_macros.svh"
module rphg_ring
    import rphg_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [31:0]      wr_data,
    output logic [SUM_W-1:0] sum,
    output logic             busy
);

    logic [31:0]      ring_reg [AVG_DEPTH];
    logic [POS_W-1:0] pos_reg;
    logic             pend_reg;
    logic [31:0]      pend_data_reg;
    logic [SUM_W-1:0] sum_reg;

    // The running sum is updated in two steps: the old slot comes out, then the new one goes in.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < AVG_DEPTH; k++)
            begin
                ring_reg[k] <= '0;
            end
            pos_reg  <= '0;
            pend_reg <= 1'b0;
            sum_reg  <= '0;
        end
        else if (wr_en)
        begin
            ring_reg[pos_reg] <= wr_data;
            sum_reg           <= sum_reg - SUM_W'(ring_reg[pos_reg]);
            pend_reg          <= 1'b1;
        end
        else if (pend_reg)
        begin
            sum_reg  <= sum_reg + SUM_W'(pend_data_reg);
            pend_reg <= 1'b0;
            if ({1'b0, pos_reg} == (POS_W+1)'(AVG_DEPTH - 1))
            begin
                pos_reg <= '0;
            end
            else
            begin
                pos_reg <= pos_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            pend_data_reg <= wr_data;
        end
    end

    assign sum  = sum_reg;
    assign busy = pend_reg;

    `RPHG_ASSERT_NOW(a_pos_range, 1'b1, {1'b0, pos_reg} < (POS_W+1)'(AVG_DEPTH))
    `RPHG_ASSERT_NEXT(a_pend_follows_wr, wr_en, pend_reg)
    `RPHG_ASSERT_NOW(a_no_wr_while_pend, pend_reg, !wr_en)

endmodule

// File: hdl/rphg_div.sv
`timescale 1ns / 1ps
`include "rotation_phase_hue_generator_top_macros.svh"
module rphg_div
    import rphg_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [31:0]      elapsed,
    input  logic [SUM_W-1:0] sum,
    output div_res_t         res
);

    div_state_t       state_reg, state_next;
    logic [SUM_W-1:0] a_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0] rem_reg, rem_next;
    logic [7:0]       low_reg, low_next;
    logic [7:0]       q_reg, q_next;
    logic [2:0]       cnt_reg, cnt_next;
    logic             done_reg, done_next;

    logic [NUM_W-1:0] num;
    logic [SUM_W:0]   trial;
    logic             fits;

    // elapsed * AVG_DEPTH * 255, formed as (a << 8) - a.
    assign num   = {a_reg, 8'd0} - NUM_W'(a_reg);
    assign trial = {rem_reg, low_reg[7]};
    assign fits  = trial >= {1'b0, sum_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= SUM_W'(elapsed) * SUM_W'(AVG_DEPTH);
            sum_reg <= sum;
        end
        rem_reg <= rem_next;
        low_reg <= low_next;
        q_reg   <= q_next;
        cnt_reg <= cnt_next;
    end

    always_comb
    begin
        state_next = state_reg;
        rem_next   = rem_reg;
        low_next   = low_reg;
        q_next     = q_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            D_IDLE:
            begin
                if (start)
                begin
                    state_next = D_PREP;
                end
            end
            D_PREP:
            begin
                // An empty ring, or a frame later than the average interval, gives phase zero.
                if (sum_reg == '0 || a_reg > sum_reg)
                begin
                    q_next     = '0;
                    done_next  = 1'b1;
                    state_next = D_IDLE;
                end
                else
                begin
                    // The quotient fits in eight bits, so the top of the numerator is below sum.
                    rem_next   = num[NUM_W-1:8];
                    low_next   = num[7:0];
                    q_next     = '0;
                    cnt_next   = '0;
                    state_next = D_RUN;
                end
            end
            D_RUN:
            begin
                rem_next = fits ? SUM_W'(trial - {1'b0, sum_reg}) : trial[SUM_W-1:0];
                low_next = {low_reg[6:0], 1'b0};
                q_next   = {q_reg[6:0], fits};
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd7)
                begin
                    done_next  = 1'b1;
                    state_next = D_IDLE;
                end
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase
    end

    assign res.done  = done_reg;
    assign res.phase = q_reg;

    `RPHG_ASSERT_NOW(a_start_when_idle, start, state_reg == D_IDLE)
    `RPHG_ASSERT_NOW(a_rem_below_sum, state_reg == D_RUN, rem_reg < sum_reg)
    `RPHG_ASSERT_NEXT(a_done_single, done_reg, !done_reg)

endmodule

// File: hdl/rphg_emit.sv
`timescale 1ns / 1ps
`include "rotation_phase_hue_generator_top_macros.svh"
module rphg_emit
    import rphg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [7:0] phase,
    input  led_cfg_t   cfg,
    output logic       busy,
    output logic       out_valid,
    input  logic       out_stall,
    output out_item_t  out_item
);

    logic             active_reg;
    logic [LED_W-1:0] idx_reg;
    logic [7:0]       hue_reg;
    logic             out_valid_reg;
    out_item_t        out_item_reg;
    logic             load;
    logic             is_last;

    assign load    = active_reg && (!out_valid_reg || !out_stall);
    assign is_last = idx_reg == LED_W'(NUM_LEDS - 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (start)
            begin
                active_reg <= 1'b1;
            end
            else if (load && is_last)
            begin
                active_reg <= 1'b0;
            end

            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // The first arm's hue is carried as a running sum, one hue step per LED.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            idx_reg <= '0;
            hue_reg <= phase;
        end
        else if (load)
        begin
            idx_reg <= idx_reg + LED_W'(1);
            hue_reg <= hue_reg + cfg.hue_step;
        end

        if (load)
        begin
            out_item_reg.led_index   <= idx_reg;
            out_item_reg.hue_a       <= hue_reg;
            out_item_reg.hue_b       <= hue_reg + cfg.arm_hue_offset;
            out_item_reg.value_level <= cfg.level;
            out_item_reg.last        <= is_last;
        end
    end

    assign busy      = active_reg;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    `RPHG_ASSERT_NOW(a_start_when_free, start, !active_reg)
    `RPHG_ASSERT_NEXT(a_stop_after_last, load && is_last, !active_reg)
    `RPHG_ASSERT_NOW(a_last_flag_index, out_valid_reg && out_item_reg.last,
                     out_item_reg.led_index == LED_W'(NUM_LEDS - 1))

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import rphg_pkg::*;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    in_item_t              in_item = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_item_t             out_item;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Predictor copy of the registers and of the rotation state.
    logic [15:0] lockout_r;
    logic [7:0]  level_r;
    logic [7:0]  step_r;
    logic [7:0]  offset_r;
    logic [31:0] rot_last_ms;
    logic [31:0] rot_ring [AVG_DEPTH];
    int          rot_pos;

    out_item_t   exp_leds [$];
    int          mismatches = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_left = 0;
    int unsigned period_ms = 100;

    rotation_phase_hue_generator_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic logic [7:0] frame_phase(input logic [31:0] elapsed);
        logic [63:0] sum;
        logic [63:0] num;
        sum = '0;
        for (int k = 0; k < AVG_DEPTH; k++)
            sum += {32'd0, rot_ring[k]};
        if (sum == 0)
            return 8'd0;
        if ({32'd0, elapsed} * 64'(AVG_DEPTH) > sum)
            return 8'd0;
        num = {32'd0, elapsed} * 64'd255 * 64'(AVG_DEPTH);
        return 8'(num / sum);
    endfunction

    // Updates the rotation state for one accepted item and queues the LED results of a frame.
    // Returns 0 only for a pulse that the lockout throws away.
    function automatic bit advance_rotor(input in_item_t it);
        logic [31:0] elapsed;
        logic [7:0]  ph;
        logic [7:0]  ha;
        out_item_t   e;
        elapsed = it.now_ms - rot_last_ms;
        if (it.op == OP_PULSE)
        begin
            if (elapsed < {16'd0, lockout_r})
                return 1'b0;
            rot_ring[rot_pos] = elapsed;
            rot_pos = (rot_pos + 1) % AVG_DEPTH;
            rot_last_ms = it.now_ms;
            return 1'b1;
        end
        ph = frame_phase(elapsed);
        for (int i = 0; i < NUM_LEDS; i++)
        begin
            ha = i[7:0] * step_r + ph;
            e.led_index   = i[LED_W-1:0];
            e.hue_a       = ha;
            e.hue_b       = ha + offset_r;
            e.value_level = level_r;
            e.last        = (i == NUM_LEDS - 1);
            exp_leds.push_back(e);
        end
        return 1'b1;
    endfunction

    task automatic send_item(input logic op, input logic [31:0] now, output bit counted);
        int       gap;
        in_item_t it;
        gap = 0;
        while (gap < 300 && $urandom_range(99) < send_idle_pct)
            gap++;
        it.op = op;
        it.now_ms = now;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        counted = advance_rotor(it);
    endtask

    task automatic send_plain(input logic op, input logic [31:0] now);
        bit counted;
        send_item(op, now, counted);
    endtask

    // Waits until every LED result has come out, then lets a pulse item finish as well.
    task automatic settle_idle();
        in_valid <= 1'b0;
        while (exp_leds.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        case (idx)
            CFG_LOCKOUT_MS:     lockout_r = data;
            CFG_LEVEL:          level_r = data[7:0];
            CFG_HUE_STEP:       step_r = data[7:0];
            CFG_ARM_HUE_OFFSET: offset_r = data[7:0];
            default:            ;
        endcase
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(9))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic random_settings();
        logic [15:0] lock;
        case ($urandom_range(3))
            0:       lock = 16'd0;
            1:       lock = 16'($urandom_range(1, 200));
            2:       lock = 16'($urandom_range(65535));
            default: lock = 16'hFFFF;
        endcase
        write_reg(CFG_LOCKOUT_MS, lock);
        write_reg(CFG_LEVEL, {8'($urandom), pick_byte()});
        write_reg(CFG_HUE_STEP, {8'($urandom), pick_byte()});
        write_reg(CFG_ARM_HUE_OFFSET, {8'($urandom), pick_byte()});
        period_ms = lockout_r + $urandom_range(1, 3000);
    endtask

    // Result checker and receiver stall generator.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (exp_leds.size() == 0)
            begin
                $display("%0t: unexpected LED result, expected none, got %p", $time, out_item);
                mismatches++;
            end
            else
            begin
                if (out_item !== exp_leds[0])
                begin
                    $display("%0t: LED result mismatch, expected %p, got %p",
                             $time, exp_leds[0], out_item);
                    mismatches++;
                end
                void'(exp_leds.pop_front());
            end
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    task automatic test_empty_ring();
        send_plain(OP_FRAME, 32'd0);
        settle_idle();
    endtask

    // Intervals of 100 ms, the first measured from time zero, with early pulses thrown away.
    task automatic test_first_pulse_lockout();
        send_plain(OP_PULSE, 32'd30);
        send_plain(OP_PULSE, 32'd100);
        send_plain(OP_FRAME, 32'd110);
        send_plain(OP_PULSE, 32'd120);
        send_plain(OP_PULSE, 32'd200);
        send_plain(OP_PULSE, 32'd300);
        send_plain(OP_PULSE, 32'd400);
        send_plain(OP_PULSE, 32'd500);
        send_plain(OP_FRAME, 32'd600);
        send_plain(OP_FRAME, 32'd550);
        send_plain(OP_FRAME, 32'd601);
        send_plain(OP_FRAME, 32'd500);
        settle_idle();
    endtask

    task automatic test_lockout_zero_wrap();
        write_reg(CFG_LOCKOUT_MS, 16'd0);
        send_plain(OP_PULSE, 32'd500);
        send_plain(OP_FRAME, 32'd580);
        send_plain(OP_PULSE, 32'hFFFF_FFFF);
        send_plain(OP_FRAME, 32'hFFFF_FFFF);
        send_plain(OP_PULSE, 32'h0000_0063);
        send_plain(OP_FRAME, 32'h0000_0095);
        settle_idle();
    endtask

    task automatic test_register_extremes();
        write_reg(CFG_LOCKOUT_MS, 16'hFFFF);
        write_reg(CFG_LEVEL, 16'hA5FF);
        write_reg(CFG_HUE_STEP, 16'h5AFF);
        write_reg(CFG_ARM_HUE_OFFSET, 16'hFF00);
        send_plain(OP_FRAME, 32'h0000_006D);
        send_plain(OP_PULSE, 32'h0000_044B);
        settle_idle();
        write_reg(CFG_LEVEL, 16'hFF00);
        write_reg(CFG_HUE_STEP, 16'h0000);
        write_reg(CFG_ARM_HUE_OFFSET, 16'h00FF);
        send_plain(OP_PULSE, 32'h0001_0062);
        send_plain(OP_FRAME, 32'h0001_0070);
        settle_idle();
    endtask

    // Mostly regular rotations with frames spread over the turn, some early pulses and noise.
    task automatic test_random_traffic(input int n, input int idle_pct, input int stall_pct,
                                       input logic [31:0] start_ms);
        int          done;
        int          r;
        logic        op;
        logic [31:0] now;
        bit          counted;
        done = 0;
        random_settings();
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        if (start_ms != 0)
            send_plain(OP_PULSE, start_ms);
        while (done < n)
        begin
            r = $urandom_range(99);
            if (r < 45)
            begin
                op = OP_PULSE;
                now = rot_last_ms + period_ms + $urandom_range(period_ms / 4) - period_ms / 8;
            end
            else if (r < 85)
            begin
                op = OP_FRAME;
                now = rot_last_ms + $urandom_range(period_ms + period_ms / 4);
            end
            else if (r < 92)
            begin
                op = OP_PULSE;
                now = rot_last_ms + ((lockout_r == 0) ? 0 : $urandom_range(lockout_r - 1));
            end
            else
            begin
                op = 1'($urandom_range(1));
                now = $urandom();
            end
            send_item(op, now, counted);
            if (counted)
                done++;
        end
        settle_idle();
    endtask

    // The receiver holds off long enough for the block to fill and stall its input.
    task automatic test_output_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_left = 500;
        for (int i = 0; i < 16; i++)
            send_plain(OP_FRAME, rot_last_ms + $urandom_range(period_ms));
        settle_idle();
    endtask

    initial
    begin
        lockout_r = LOCKOUT_MS_RST;
        level_r = LEVEL_RST;
        step_r = HUE_STEP_RST;
        offset_r = ARM_HUE_OFFSET_RST;
        rot_last_ms = '0;
        for (int k = 0; k < AVG_DEPTH; k++)
            rot_ring[k] = '0;
        rot_pos = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_ring();
        test_first_pulse_lockout();
        test_lockout_zero_wrap();
        test_register_extremes();
        test_random_traffic(100, 0, 0, 32'd0);
        test_random_traffic(100, 82, 0, 32'd0);
        test_random_traffic(100, 0, 82, 32'd0);
        test_random_traffic(100, 15, 15, 32'hFFFF_F000);
        test_output_backpressure();

        repeat (50) @(posedge clk);
        if (mismatches == 0 && exp_leds.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
